// ===== rtl/strided_byte_pattern_search_core_assert.svh =====
// assertion macros shared by the checker
`ifndef STRIDED_BYTE_PATTERN_SEARCH_CORE_ASSERT_SVH
`define STRIDED_BYTE_PATTERN_SEARCH_CORE_ASSERT_SVH

// same-cycle implication, ignored while reset is high
`define SBPS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication, ignored while reset is high
`define SBPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication that also holds across reset
`define SBPS_ASSERT_RESET(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ===== rtl/sbps_pkg.sv =====
`default_nettype none
package sbps_pkg;

   localparam int BYTE_BITS          = 8;
   localparam int PATTERN_BYTES      = 32;
   localparam int LEN_BITS           = 6;
   localparam int RESULT_OFFSET_BITS = 32;
   localparam int COUNT_BITS         = 32;
   localparam int CSR_DATA_BITS      = 64;
   localparam int CSR_INDEX_BITS     = 3;

   localparam logic [RESULT_OFFSET_BITS-1:0] RESULT_OFFSET_MAX = '1;

   typedef logic [PATTERN_BYTES-1:0][BYTE_BITS-1:0] pattern_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_0_7   = 3'd0,
      CSR_PATTERN_8_15  = 3'd1,
      CSR_PATTERN_16_23 = 3'd2,
      CSR_PATTERN_24_31 = 3'd3,
      CSR_PATTERN_LEN   = 3'd4,
      CSR_STRIDE_KIND   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      STRIDE_ONE  = 2'd0,
      STRIDE_HALF = 2'd1,
      STRIDE_FULL = 2'd2
   } stride_kind_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   typedef struct packed {
      logic                          match_found;
      logic [RESULT_OFFSET_BITS-1:0] match_offset;
      logic [LEN_BITS-1:0]           match_length;
      logic                          search_done;
      logic [COUNT_BITS-1:0]         total_found;
      logic                          offset_overflow;
   } result_type;

endpackage
`default_nettype wire

// ===== rtl/sbps_req_if.sv =====
`default_nettype none
interface sbps_req_if import sbps_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] data_byte;
   logic                 last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/sbps_rsp_if.sv =====
`default_nettype none
interface sbps_rsp_if import sbps_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          match_found;
   logic [RESULT_OFFSET_BITS-1:0] match_offset;
   logic [LEN_BITS-1:0]           match_length;
   logic                          search_done;
   logic [COUNT_BITS-1:0]         total_found;
   logic                          offset_overflow;

   modport source (output valid, output match_found, output match_offset,
                   output match_length, output search_done, output total_found,
                   output offset_overflow, input ready);
   modport sink   (input valid, input match_found, input match_offset,
                   input match_length, input search_done, input total_found,
                   input offset_overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/strided_byte_pattern_search_core.sv =====
// Strided byte pattern search: takes one file byte per beat on req_bus and
// returns a result on rsp_bus for every byte that completes a matching
// candidate window and for the byte marked last (done, with the match count).
// A new byte is taken every clock cycle; the only stall comes from a full
// two-entry result buffer when rsp_bus is backpressured. Results leave from
// the buffer's registers, not straight from the input. The cycle time is set by the window
// compare: MAX_PATTERN cells each match their byte against a pattern byte
// chosen by the current length, reduced to one hit bit, together with the
// candidate countdown update. Configure only while no file is in flight.
`default_nettype none
module strided_byte_pattern_search_core import sbps_pkg::*; #(
   parameter int MAX_PATTERN = 32,
   parameter int OFFSET_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   sbps_req_if.sink                       req_bus,
   sbps_rsp_if.source                     rsp_bus,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int WIDE_BITS = (OFFSET_BITS > RESULT_OFFSET_BITS) ? OFFSET_BITS
                                                                 : RESULT_OFFSET_BITS;

   // configuration
   pattern_type         pattern_ff;
   logic [LEN_BITS-1:0] len_ff;
   logic [1:0]          kind_ff;

   // running state
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [LEN_BITS-1:0]    btc_ff, btc_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   sat_ff, sat_in;

   logic [LEN_BITS-1:0]    len_eff, len_m1, half_len, stride, stride_m1, btc_cur;
   logic                   accept, last, test, hit, produce, can_push;
   logic [OFFSET_BITS-1:0] start_pos;
   logic [WIDE_BITS-1:0]   start_wide;
   result_type             result, head;
   cell_ctrl_type          cell_ctrl;

   logic [BYTE_BITS-1:0]   window_q [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] match_vec;

   assign accept = req_bus.valid && req_bus.ready;
   assign last   = req_bus.last_byte;
   assign req_bus.ready = can_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         len_ff     <= LEN_BITS'(1);
         kind_ff    <= STRIDE_ONE;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_0_7:   pattern_ff[7:0]   <= csr_wdata;
            CSR_PATTERN_8_15:  pattern_ff[15:8]  <= csr_wdata;
            CSR_PATTERN_16_23: pattern_ff[23:16] <= csr_wdata;
            CSR_PATTERN_24_31: pattern_ff[31:24] <= csr_wdata;
            CSR_PATTERN_LEN:   len_ff  <= csr_wdata[LEN_BITS-1:0];
            CSR_STRIDE_KIND:   kind_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // effective length and stride
   always_comb begin
      if (len_ff == '0) begin
         len_eff = LEN_BITS'(1);
      end else if (len_ff > LEN_BITS'(MAX_PATTERN)) begin
         len_eff = LEN_BITS'(MAX_PATTERN);
      end else begin
         len_eff = len_ff;
      end
      len_m1   = len_eff - LEN_BITS'(1);
      half_len = len_eff >> 1;
      case (stride_kind_type'(kind_ff))
         STRIDE_HALF: stride = (half_len == '0) ? LEN_BITS'(1) : half_len;
         STRIDE_FULL: stride = len_eff;
         default:     stride = LEN_BITS'(1);
      endcase
      stride_m1 = stride - LEN_BITS'(1);
   end

   assign cell_ctrl.shift = accept;
   assign cell_ctrl.clear = accept && last;

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      logic [BYTE_BITS-1:0] prev_byte;
      if (j == 0) begin : g_head
         assign prev_byte = req_bus.data_byte;
      end else begin : g_link
         assign prev_byte = window_q[j-1];
      end
      sbps_cell #(
         .CELL_INDEX (j)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .prev_byte (prev_byte),
         .pattern   (pattern_ff),
         .eff_len   (len_eff),
         .byte_q    (window_q[j]),
         .match_ok  (match_vec[j])
      );
   end

   always_comb begin
      // countdown reloads from the current length at the start of a file
      btc_cur  = (pos_ff == '0 && !sat_ff) ? len_m1 : btc_ff;
      test     = (btc_cur == '0) && (pos_ff >= OFFSET_BITS'(len_m1));
      hit      = test && (&match_vec);
      produce  = hit || last;

      if (btc_cur == '0) begin
         btc_in = hit ? len_m1 : stride_m1;
      end else begin
         btc_in = btc_cur - LEN_BITS'(1);
      end

      count_in = count_ff;
      if (hit && count_ff != '1) begin
         count_in = count_ff + COUNT_BITS'(1);
      end

      if (pos_ff == '1) begin
         pos_in = pos_ff;
         sat_in = 1'b1;
      end else begin
         pos_in = pos_ff + OFFSET_BITS'(1);
         sat_in = sat_ff;
      end

      start_pos  = pos_ff - OFFSET_BITS'(len_m1);
      start_wide = WIDE_BITS'(start_pos);

      result.match_found  = hit;
      if (!hit) begin
         result.match_offset = '0;
      end else if (start_wide > WIDE_BITS'(RESULT_OFFSET_MAX)) begin
         result.match_offset = RESULT_OFFSET_MAX;
      end else begin
         result.match_offset = start_wide[RESULT_OFFSET_BITS-1:0];
      end
      result.match_length    = len_eff;
      result.search_done     = last;
      result.total_found     = count_in;
      result.offset_overflow = sat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         btc_ff   <= '0;
         count_ff <= '0;
         sat_ff   <= 1'b0;
      end else if (accept) begin
         if (last) begin
            pos_ff   <= '0;
            btc_ff   <= len_m1;
            count_ff <= '0;
            sat_ff   <= 1'b0;
         end else begin
            pos_ff   <= pos_in;
            btc_ff   <= btc_in;
            count_ff <= count_in;
            sat_ff   <= sat_in;
         end
      end
   end

   sbps_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && produce),
      .push_data  (result),
      .can_push   (can_push),
      .head_valid (rsp_bus.valid),
      .head_ready (rsp_bus.ready),
      .head       (head)
   );

   assign rsp_bus.match_found     = head.match_found;
   assign rsp_bus.match_offset    = head.match_offset;
   assign rsp_bus.match_length    = head.match_length;
   assign rsp_bus.search_done     = head.search_done;
   assign rsp_bus.total_found     = head.total_found;
   assign rsp_bus.offset_overflow = head.offset_overflow;

endmodule
`default_nettype wire

// ===== rtl/sbps_cell.sv =====
`default_nettype none
module sbps_cell import sbps_pkg::*; #(
   parameter int CELL_INDEX = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cell_ctrl_type        ctrl,
   input  wire logic [BYTE_BITS-1:0] prev_byte,
   input  wire pattern_type          pattern,
   input  wire logic [LEN_BITS-1:0]  eff_len,
   output logic      [BYTE_BITS-1:0] byte_q,
   output logic                      match_ok
);

   logic [BYTE_BITS-1:0] byte_ff;
   logic [LEN_BITS:0]    pat_dist;
   logic [LEN_BITS-1:0]  pat_idx;
   logic [BYTE_BITS-1:0] pat_byte;
   logic                 unused_cell;

   // this cell holds window entry CELL_INDEX and meets pattern byte len-1-CELL_INDEX
   always_comb begin
      unused_cell = ((LEN_BITS+1)'(CELL_INDEX) >= {1'b0, eff_len});
      pat_dist    = {1'b0, eff_len} - (LEN_BITS+1)'(CELL_INDEX) - (LEN_BITS+1)'(1);
      pat_idx     = pat_dist[LEN_BITS-1:0];
      if (pat_idx < LEN_BITS'(PATTERN_BYTES)) begin
         pat_byte = pattern[pat_idx[$clog2(PATTERN_BYTES)-1:0]];
      end else begin
         pat_byte = '0;
      end
      // compare against the byte entering this cell on the current beat
      match_ok = unused_cell || (prev_byte == pat_byte);
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         byte_ff <= '0;
      end else if (ctrl.shift) begin
         byte_ff <= prev_byte;
      end
   end

   assign byte_q = byte_ff;

endmodule
`default_nettype wire

// ===== rtl/sbps_out_buf.sv =====
`default_nettype none
module sbps_out_buf import sbps_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   output logic            can_push,
   output logic            head_valid,
   input  wire logic       head_ready,
   output result_type      head
);

   logic [1:0] count_ff, count_in;
   result_type head_ff, head_in;
   result_type tail_ff, tail_in;
   logic       pop;

   assign pop = head_valid && head_ready;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case (count_ff)
         2'd0: begin
            if (push) begin
               head_in  = push_data;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = push_data;
            end else if (push) begin
               tail_in  = push_data;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in  = tail_ff;
               count_in = 2'd1;
            end
         end
         default: begin
            count_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign can_push   = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = head_ff;

endmodule
`default_nettype wire

// ===== rtl/sbps_checker.sv =====
`default_nettype none
`include "strided_byte_pattern_search_core_assert.svh"
module sbps_checker import sbps_pkg::*; (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_match_found,
   input wire logic [RESULT_OFFSET_BITS-1:0] rsp_match_offset,
   input wire logic [LEN_BITS-1:0]           rsp_match_length,
   input wire logic                          rsp_search_done
);

   `SBPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `SBPS_ASSERT_NOW(a_rsp_has_cause, rsp_valid, rsp_match_found || rsp_search_done)
   `SBPS_ASSERT_NOW(a_rsp_len_nonzero, rsp_valid, rsp_match_length != '0)
   `SBPS_ASSERT_NOW(a_nomatch_offset_zero, rsp_valid && !rsp_match_found,
                    rsp_match_offset == '0)
   `SBPS_ASSERT_RESET(a_reset_empty, reset, !rsp_valid)

endmodule

bind strided_byte_pattern_search_core sbps_checker u_sbps_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_match_found  (rsp_bus.match_found),
   .rsp_match_offset (rsp_bus.match_offset),
   .rsp_match_length (rsp_bus.match_length),
   .rsp_search_done  (rsp_bus.search_done)
);
`default_nettype wire

// ===== tb/search_result_monitor.sv =====
module search_result_monitor import sbps_pkg::*; #(
   parameter int OFFSET_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   sbps_req_if                            req_mon,
   sbps_rsp_if                            rsp_mon,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int unsigned                    mismatches,
   output int unsigned                    pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned POS_LIMIT = (64'd1 << OFFSET_BITS) - 64'd1;

   // register copies
   logic [CSR_DATA_BITS-1:0] pattern_word [4];
   logic [LEN_BITS-1:0]      len_reg;
   logic [1:0]               kind_reg;

   // running search state
   logic [BYTE_BITS-1:0]     history [PATTERN_BYTES];
   longint unsigned          position;
   logic [LEN_BITS-1:0]      countdown;
   logic [COUNT_BITS-1:0]    hits;
   bit                       saturated;

   result_type               expected_results [$];

   function automatic int unsigned window_len();
      int unsigned n;
      n = len_reg;
      if (n == 0) n = 1;
      if (n > PATTERN_BYTES) n = PATTERN_BYTES;
      return n;
   endfunction

   function automatic int unsigned stride_of(input int unsigned n);
      case (kind_reg)
         STRIDE_HALF: return (n / 2 != 0) ? n / 2 : 1;
         STRIDE_FULL: return n;
         default:     return 1;
      endcase
   endfunction

   function automatic logic [BYTE_BITS-1:0] pattern_at(input int unsigned k);
      return pattern_word[k / 8][8 * (k % 8) +: 8];
   endfunction

   task automatic start_file();
      int i;
      for (i = 0; i < PATTERN_BYTES; i++) history[i] = '0;
      position  = 0;
      countdown = LEN_BITS'(window_len() - 1);
      hits      = '0;
      saturated = 1'b0;
   endtask

   task automatic predict_beat(input logic [BYTE_BITS-1:0] d, input logic fin);
      int unsigned     n, k;
      int              i;
      longint unsigned here, first;
      bit              hit, clamped;
      result_type      r;
      n       = window_len();
      here    = position;
      clamped = saturated;
      hit     = 1'b0;
      first   = 0;
      // countdown restarts from the current length at the top of a file
      if (here == 0 && !saturated) countdown = LEN_BITS'(n - 1);
      for (i = PATTERN_BYTES - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = d;
      if (countdown == 0) begin
         // a window reaching before offset 0 is skipped
         if (here + 1 >= n) begin
            hit = 1'b1;
            for (k = 0; k < n; k++) begin
               if (history[n-1-k] != pattern_at(k)) hit = 1'b0;
            end
            first = here + 1 - n;
         end
         if (hit) begin
            countdown = LEN_BITS'(n - 1);
            if (hits != '1) hits++;
         end else begin
            countdown = LEN_BITS'(stride_of(n) - 1);
         end
      end else begin
         countdown--;
      end
      if (here >= POS_LIMIT) saturated = 1'b1;
      else position = here + 1;
      if (hit || fin) begin
         r.match_found     = hit;
         r.match_offset    = !hit ? '0 :
                             (first > 64'hFFFF_FFFF) ? RESULT_OFFSET_MAX :
                             RESULT_OFFSET_BITS'(first);
         r.match_length    = LEN_BITS'(n);
         r.search_done     = fin;
         r.total_found     = hits;
         r.offset_overflow = clamped;
         expected_results.push_back(r);
         if (fin) start_file();
      end
   endtask

   function automatic void compare_field(input string label, input logic [63:0] want,
                                         input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      end
   endfunction

   task automatic check_result();
      result_type want;
      if (expected_results.size() == 0) begin
         mismatches++;
         $display("%0t: result beat with none expected, expected nothing, actual %0h",
                  $time, rsp_mon.match_offset);
         return;
      end
      want = expected_results.pop_front();
      compare_field("match_found", want.match_found, rsp_mon.match_found);
      compare_field("match_offset", want.match_offset, rsp_mon.match_offset);
      compare_field("match_length", want.match_length, rsp_mon.match_length);
      compare_field("search_done", want.search_done, rsp_mon.search_done);
      compare_field("total_found", want.total_found, rsp_mon.total_found);
      compare_field("offset_overflow", want.offset_overflow, rsp_mon.offset_overflow);
   endtask

   initial begin
      mismatches      = 0;
      pending_results = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         pattern_word[0] = '0;
         pattern_word[1] = '0;
         pattern_word[2] = '0;
         pattern_word[3] = '0;
         len_reg         = LEN_BITS'(1);
         kind_reg        = STRIDE_ONE;
         start_file();
         expected_results.delete();
      end else begin
         // a result only appears after its byte has been taken, so check before predicting
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) check_result();
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            predict_beat(req_mon.data_byte, req_mon.last_byte);
         if (csr_we) begin
            case (csr_index)
               CSR_PATTERN_0_7:   pattern_word[0] = csr_wdata;
               CSR_PATTERN_8_15:  pattern_word[1] = csr_wdata;
               CSR_PATTERN_16_23: pattern_word[2] = csr_wdata;
               CSR_PATTERN_24_31: pattern_word[3] = csr_wdata;
               CSR_PATTERN_LEN:   len_reg = csr_wdata[LEN_BITS-1:0];
               CSR_STRIDE_KIND:   kind_reg = csr_wdata[1:0];
               default: ;
            endcase
         end
      end
      pending_results = expected_results.size();
   end

endmodule

// ===== tb/strided_byte_pattern_search_core_test.sv =====
module strided_byte_pattern_search_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sbps_pkg::*;

   localparam int unsigned ITEM_TARGET   = 1350;
   localparam logic [1:0]  STRIDE_SPARE  = 2'd3;  // unused code, acts as one byte

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   int unsigned               mismatches;
   int unsigned               pending_results;

   int unsigned               send_idle_pct;
   int unsigned               recv_idle_pct;
   int unsigned               hold_cycles;
   int unsigned               beats_sent;
   int unsigned               drain_cycles;

   pattern_type               pat_now;
   logic [LEN_BITS-1:0]       len_now;
   logic [1:0]                kind_now;

   sbps_req_if req_bus ();
   sbps_rsp_if rsp_bus ();

   strided_byte_pattern_search_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   search_result_monitor result_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // result side: random stalls plus long hold-offs on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic int unsigned used_len(input logic [LEN_BITS-1:0] l);
      if (l == 0) return 1;
      if (l > PATTERN_BYTES) return PATTERN_BYTES;
      return l;
   endfunction

   task automatic csr_put(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(negedge clock);
   endtask

   task automatic load_config();
      csr_put(CSR_PATTERN_0_7, pat_now[7:0]);
      csr_put(CSR_PATTERN_8_15, pat_now[15:8]);
      csr_put(CSR_PATTERN_16_23, pat_now[23:16]);
      csr_put(CSR_PATTERN_24_31, pat_now[31:24]);
      csr_put(CSR_PATTERN_LEN, CSR_DATA_BITS'(len_now));
      csr_put(CSR_STRIDE_KIND, CSR_DATA_BITS'(kind_now));
      csr_we <= 1'b0;
   endtask

   task automatic send_byte(input logic [BYTE_BITS-1:0] d, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= d;
      req_bus.last_byte <= fin;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   // drop valid and let every expected result drain before touching registers
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic pick_config();
      int k;
      logic [BYTE_BITS-1:0] fill;
      case ($urandom_range(9))
         0:       len_now = '0;
         1:       len_now = LEN_BITS'($urandom_range(33, 63));
         2:       len_now = LEN_BITS'(PATTERN_BYTES);
         3:       len_now = LEN_BITS'($urandom_range(9, 31));
         default: len_now = LEN_BITS'($urandom_range(1, 8));
      endcase
      kind_now = 2'($urandom_range(3));
      fill     = 8'($urandom);
      // a run of one repeated byte makes candidates crowd each other
      for (k = 0; k < PATTERN_BYTES; k++)
         pat_now[k] = ($urandom_range(4) == 0) ? fill : 8'($urandom);
      if ($urandom_range(4) == 0) begin
         for (k = 0; k < PATTERN_BYTES; k++) pat_now[k] = fill;
      end
   endtask

   task automatic run_file();
      logic [BYTE_BITS-1:0] file_bytes [$];
      int unsigned          n, size, k, broken;
      n    = used_len(len_now);
      size = (n > 8) ? $urandom_range(n, 3 * n) : $urandom_range(1, 24);
      while (file_bytes.size() < size) begin
         case ($urandom_range(3))
            0, 1: begin
               // copy of the pattern, now and then with one byte spoiled
               broken = ($urandom_range(3) == 0) ? $urandom_range(n - 1) : n;
               for (k = 0; k < n; k++)
                  file_bytes.push_back((k == broken) ? 8'($urandom) : pat_now[k]);
            end
            2:       file_bytes.push_back(pat_now[$urandom_range(n - 1)]);
            default: file_bytes.push_back(8'($urandom));
         endcase
      end
      while (file_bytes.size() > size) void'(file_bytes.pop_back());
      foreach (file_bytes[j]) send_byte(file_bytes[j], j == file_bytes.size() - 1);
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      csr_we            = 1'b0;
      csr_index         = CSR_PATTERN_0_7;
      csr_wdata         = '0;
      reset             = 1'b1;
      send_idle_pct     = 18;
      recv_idle_pct     = 75;
      hold_cycles       = 0;
      beats_sent        = 0;
      drain_cycles      = 0;
      pat_now           = '0;
      len_now           = LEN_BITS'(1);
      kind_now          = STRIDE_ONE;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // registers as they come out of reset: one zero byte
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      settle();

      // zero length and the spare stride code
      pat_now[0] = 8'hFF;
      len_now    = '0;
      kind_now   = STRIDE_SPARE;
      load_config();
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      settle();

      // registers change while a file is open, to a length above the maximum
      pat_now    = {8{32'($urandom)}};
      pat_now[0] = 8'h5A;
      pat_now[1] = 8'hA5;
      len_now    = LEN_BITS'(2);
      kind_now   = STRIDE_FULL;
      load_config();
      send_byte(8'h5A, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b0);
      settle();
      len_now  = LEN_BITS'(40);
      kind_now = STRIDE_HALF;
      load_config();
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b1);
      settle();

      // every byte matches while the result side holds off: input must back up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      pat_now       = '0;
      pat_now[0]    = 8'h3C;
      len_now       = LEN_BITS'(1);
      kind_now      = STRIDE_ONE;
      load_config();
      hold_cycles = 120;
      repeat (29) send_byte(8'h3C, 1'b0);
      send_byte(8'h3C, 1'b1);
      settle();

      while (beats_sent < ITEM_TARGET) begin
         if (beats_sent < 500) begin
            send_idle_pct = 18;
            recv_idle_pct = 75;
         end else if (beats_sent < 950) begin
            send_idle_pct = 75;
            recv_idle_pct = 18;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if ($urandom_range(4) < 2) begin
            settle();
            pick_config();
            load_config();
         end
         run_file();
      end

      req_bus.valid <= 1'b0;
      recv_idle_pct = 0;
      while (pending_results != 0 && drain_cycles < 5000) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (10) @(negedge clock);
      if (pending_results != 0)
         $display("%0t: %0d expected results never arrived", $time, pending_results);
      if (mismatches == 0 && pending_results == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sbps_pkg.sv
rtl/sbps_req_if.sv
rtl/sbps_rsp_if.sv
rtl/sbps_cell.sv
rtl/sbps_out_buf.sv
rtl/strided_byte_pattern_search_core.sv
rtl/sbps_checker.sv
tb/search_result_monitor.sv
tb/strided_byte_pattern_search_core_test.sv
